// File: design/fclc_pkg.sv
// Shared types, codes and constants for the Fourier coefficient layout converter.
package fclc_pkg;

  // Default sizing of the coefficient set
  localparam int MAX_M_DEF = 16;
  localparam int MAX_N_DEF = 16;

  // Fixed field widths
  localparam int VAL_W     = 32;
  localparam int M_W       = 4;
  localparam int N_W       = 6;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 3;

  // round(2^31 / sqrt2)
  localparam logic signed [VAL_W-1:0] KSQ = 32'sd1518500250;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOR_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_PARITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE     = 3'd4;

  typedef logic [2:0] op_t;

  // Command codes passed from front to back
  localparam op_t OP_F_M0    = 3'd0;  // forward, m = 0
  localparam op_t OP_F_STORE = 3'd1;  // forward, m > 0, n < 0: buffer half value
  localparam op_t OP_F_MID   = 3'd2;  // forward, m > 0, n = 0
  localparam op_t OP_F_PAIR  = 3'd3;  // forward, m > 0, n > 0: combine with buffer
  localparam op_t OP_I_M0    = 3'd4;  // inverse, m = 0
  localparam op_t OP_I_STORE = 3'd5;  // inverse, m > 0, buffer a row element
  localparam op_t OP_I_ROW   = 3'd6;  // inverse, m > 0, last element: emit the row

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [M_W-1:0]          m;
    logic signed [N_W-1:0]   n;
    logic                    set_end;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [M_W-1:0]          m;
    logic signed [N_W-1:0]   n;
    logic                    row_end;
    logic                    set_end;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  // Bits needed to hold the values 0..max_v
  function automatic int idx_bits(input int max_v);
    return (max_v > 0) ? $clog2(max_v + 1) : 1;
  endfunction

endpackage

// File: design/fclc_fifo.sv
// Small synchronous FIFO used for the command queue and the result queue.
module fclc_fifo #(
  parameter int WIDTH = fclc_pkg::CMD_W,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import fclc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = idx_bits(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rptr_r];

  // Pointer and occupancy update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= data_i;
    end
  end

endmodule

// File: design/fclc_front.sv
// Front end: tracks the (m, n) position of each request and classifies it into a command.
module fclc_front #(
  parameter int MAX_M = fclc_pkg::MAX_M_DEF,
  parameter int MAX_N = fclc_pkg::MAX_N_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push_i,
  input  logic signed [fclc_pkg::VAL_W-1:0]      value_a_i,
  input  logic signed [fclc_pkg::VAL_W-1:0]      value_b_i,
  input  logic                                   clear_i,
  input  logic [fclc_pkg::idx_bits(MAX_M)-1:0]   eff_m_i,
  input  logic [fclc_pkg::idx_bits(MAX_N)-1:0]   eff_n_i,
  input  logic                                   inverse_i,
  input  logic                                   cmd_full_i,
  output logic                                   cmd_push_o,
  output fclc_pkg::cmd_t                         cmd_o
);
  import fclc_pkg::*;

  localparam int RW = (MAX_M > 1) ? $clog2(MAX_M) : 1;
  localparam int MW = idx_bits(MAX_M);
  localparam int CW = idx_bits(2 * MAX_N);

  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              accept;
  logic              fwd_mid;
  logic [6:0]        col7, n7, len7, col_inc;
  logic signed [6:0] n_full;
  logic [MW:0]       row_inc;
  logic              col_last, row_last;
  op_t               op;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  // Position arithmetic
  assign col7     = 7'(col_r);
  assign n7       = 7'(eff_n_i);
  assign fwd_mid  = !inverse_i && (row_r != '0);
  assign n_full   = fwd_mid ? $signed(col7 - n7) : $signed(col7);
  assign len7     = fwd_mid ? (n7 + n7 + 7'd1) : (n7 + 7'd1);
  assign col_inc  = col7 + 7'd1;
  assign col_last = (col_inc >= len7);
  assign row_inc  = (MW + 1)'(row_r) + (MW + 1)'(1);
  assign row_last = (row_inc >= (MW + 1)'(eff_m_i));

  // Classify the request
  always_comb begin
    if (inverse_i) begin
      if (row_r == '0) begin
        op = OP_I_M0;
      end else if (col7 < n7) begin
        op = OP_I_STORE;
      end else begin
        op = OP_I_ROW;
      end
    end else begin
      if (row_r == '0) begin
        op = OP_F_M0;
      end else if (n_full < 0) begin
        op = OP_F_STORE;
      end else if (n_full == 0) begin
        op = OP_F_MID;
      end else begin
        op = OP_F_PAIR;
      end
    end
  end

  always_comb begin
    cmd_o.op      = op;
    cmd_o.a       = value_a_i;
    cmd_o.b       = value_b_i;
    cmd_o.m       = M_W'(row_r);
    cmd_o.n       = n_full[N_W-1:0];
    cmd_o.set_end = col_last && row_last;
  end

  // Position advance; a register write restarts the set
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (clear_i) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: design/fclc_back.sv
// Back end: executes commands, holds the row buffers and sequences inverse row output.
module fclc_back #(
  parameter int MAX_N = fclc_pkg::MAX_N_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fclc_pkg::cmd_t                       cmd_i,
  input  logic                                 cmd_empty_i,
  output logic                                 cmd_pop_o,
  input  logic [fclc_pkg::idx_bits(MAX_N)-1:0] eff_n_i,
  input  logic                                 three_d_i,
  input  logic                                 sine_i,
  output fclc_pkg::res_t                       res_o,
  output logic                                 res_push_o,
  input  logic                                 res_full_i
);
  import fclc_pkg::*;

  localparam int NW = idx_bits(MAX_N);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_MUL      = 2'd1;
  localparam logic [1:0] ST_EMIT     = 2'd2;
  localparam logic [1:0] ST_EMIT_MUL = 2'd3;

  localparam logic signed [63:0] RND_DIV = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] RND_MUL = 64'sh0000_0000_2000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? VAL_MIN : VAL_MAX;
    end
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return VAL_MAX;
    end
    if (v < -64'sd2147483648) begin
      return VAL_MIN;
    end
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] v);
    return (v == VAL_MIN) ? VAL_MAX : -v;
  endfunction

  function automatic logic [N_W-1:0] abs_n(input logic signed [N_W-1:0] v);
    return v[N_W-1] ? N_W'(-v) : N_W'(v);
  endfunction

  logic [1:0]              state_r, state_nxt;
  cmd_t                    cur_r, cur_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic signed [N_W-1:0]   emit_n_r, emit_n_nxt;

  logic signed [31:0]      store_a_r [0:MAX_N];
  logic signed [31:0]      store_b_r [0:MAX_N];

  logic [N_W-1:0]          head_abs, emit_abs;
  logic [NW-1:0]           head_an, emit_an, rd_idx;
  logic signed [31:0]      rd_a, rd_b;
  logic                    wr_a_en, wr_b_en;
  logic signed [31:0]      wr_a_data, wr_b_data;

  logic signed [31:0]      mul_x;
  logic signed [63:0]      mul_prod;
  logic signed [N_W-1:0]   eff_n6;

  logic signed [31:0]      half_x;
  logic signed [31:0]      pair_a, pair_b;
  logic                    emit_add, emit_last, emit_pos;
  logic signed [31:0]      emit_val;
  logic                    fin_div;
  logic signed [63:0]      round_sum, rounded;
  logic signed [31:0]      scaled, scaled_neg;
  logic                    cur_pos;
  res_t                    mul_res, pair_res, emit_res, mid_res;

  // Row buffer addressing: one read port per array
  assign head_abs = abs_n(cmd_i.n);
  assign emit_abs = abs_n(emit_n_r);
  assign head_an  = head_abs[NW-1:0];
  assign emit_an  = emit_abs[NW-1:0];
  assign rd_idx   = (state_r == ST_EMIT) ? emit_an : head_an;
  assign rd_a     = store_a_r[rd_idx];
  assign rd_b     = store_b_r[rd_idx];

  assign eff_n6   = $signed(N_W'(eff_n_i));

  // Shared sqrt2 multiplier, registered before rounding
  assign mul_prod = mul_x * KSQ;

  // Forward pair: half value against the buffered negative-n half
  assign half_x = $signed(32'((33'(cmd_i.a) + 33'sd1) >>> 1));
  assign pair_a = sat33(33'(rd_a) + 33'(half_x));
  always_comb begin
    if (!three_d_i) begin
      pair_b = '0;
    end else if (sine_i) begin
      pair_b = sat33(33'(rd_a) - 33'(half_x));
    end else begin
      pair_b = sat33(33'(half_x) - 33'(rd_a));
    end
  end

  always_comb begin
    pair_res.a       = pair_a;
    pair_res.b       = pair_b;
    pair_res.m       = cmd_i.m;
    pair_res.n       = cmd_i.n;
    pair_res.row_end = 1'b1;
    pair_res.set_end = cmd_i.set_end;
  end

  // Inverse row element: a plus or minus b depending on sign of n and parity
  assign emit_pos  = !emit_n_r[N_W-1] && (emit_n_r != '0);
  assign emit_add  = emit_pos ^ sine_i;
  assign emit_val  = emit_add ? sat33(33'(rd_a) + 33'(rd_b)) : sat33(33'(rd_a) - 33'(rd_b));
  assign emit_last = (emit_n_r == eff_n6);

  always_comb begin
    emit_res.a       = emit_val;
    emit_res.b       = '0;
    emit_res.m       = cur_r.m;
    emit_res.n       = emit_n_r;
    emit_res.row_end = emit_last;
    emit_res.set_end = emit_last && cur_r.set_end;
  end

  // Rounding of the registered product: divide by sqrt2 shifts 31, multiply shifts 30
  assign fin_div    = (state_r == ST_MUL) && (cur_r.op != OP_I_M0);
  assign round_sum  = prod_r + (fin_div ? RND_DIV : RND_MUL);
  assign rounded    = fin_div ? (round_sum >>> 31) : (round_sum >>> 30);
  assign scaled     = sat64(rounded);
  assign scaled_neg = sat_neg(scaled);
  assign cur_pos    = (cur_r.n != '0);

  // Result of a multiplier command
  always_comb begin
    mul_res.a       = '0;
    mul_res.b       = '0;
    mul_res.m       = cur_r.m;
    mul_res.n       = cur_r.n;
    mul_res.row_end = 1'b1;
    mul_res.set_end = cur_r.set_end;
    case (cur_r.op)
      OP_F_M0: begin
        if (!sine_i) begin
          mul_res.a = cur_pos ? scaled : cur_r.a;
        end else if (three_d_i && cur_pos) begin
          mul_res.b = scaled_neg;
        end
      end
      OP_F_MID: begin
        mul_res.a = scaled;
      end
      OP_I_M0: begin
        if (!sine_i) begin
          mul_res.a = cur_pos ? scaled : cur_r.a;
        end else if (cur_pos) begin
          mul_res.a = scaled_neg;
        end
      end
      default: begin
        mul_res.a = '0;
      end
    endcase
  end

  // Center (n = 0) element of an inverse row
  always_comb begin
    mid_res.a       = scaled;
    mid_res.b       = '0;
    mid_res.m       = cur_r.m;
    mid_res.n       = '0;
    mid_res.row_end = (eff_n6 == '0);
    mid_res.set_end = (eff_n6 == '0) && cur_r.set_end;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prod_nxt   = prod_r;
    emit_n_nxt = emit_n_r;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = pair_res;
    wr_a_en    = 1'b0;
    wr_b_en    = 1'b0;
    wr_a_data  = cmd_i.a;
    wr_b_data  = cmd_i.b;
    mul_x      = cmd_i.a;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_F_STORE: begin
              cmd_pop_o = 1'b1;
              wr_a_en   = 1'b1;
              wr_a_data = half_x;
            end
            OP_I_STORE: begin
              cmd_pop_o = 1'b1;
              wr_a_en   = 1'b1;
              wr_b_en   = 1'b1;
            end
            OP_I_ROW: begin
              cmd_pop_o  = 1'b1;
              wr_a_en    = 1'b1;
              wr_b_en    = 1'b1;
              cur_nxt    = cmd_i;
              emit_n_nxt = -eff_n6;
              state_nxt  = ST_EMIT;
            end
            OP_F_PAIR: begin
              if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
              end
            end
            OP_F_M0, OP_F_MID, OP_I_M0: begin
              cmd_pop_o = 1'b1;
              cur_nxt   = cmd_i;
              mul_x     = (cmd_i.op == OP_I_M0 && sine_i) ? cmd_i.b : cmd_i.a;
              prod_nxt  = mul_prod;
              state_nxt = ST_MUL;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        res_o = mul_res;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        res_o = emit_res;
        if (emit_n_r == '0) begin
          mul_x     = rd_a;
          prod_nxt  = mul_prod;
          state_nxt = ST_EMIT_MUL;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_n_nxt = emit_n_r + N_W'(1);
          end
        end
      end
      ST_EMIT_MUL: begin
        res_o = mid_res;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (eff_n6 == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_n_nxt = N_W'(1);
            state_nxt  = ST_EMIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers and row buffers, no reset
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    prod_r   <= prod_nxt;
    emit_n_r <= emit_n_nxt;
    if (wr_a_en) begin
      store_a_r[head_an] <= wr_a_data;
    end
    if (wr_b_en) begin
      store_b_r[head_an] <= wr_b_data;
    end
  end

endmodule

// File: design/fourier_coef_layout_convert_unit.sv
// Top level of the Fourier coefficient layout converter: config registers, front, queues, back.
// Path: a forward pair or store is handled in the back end's ST_IDLE; sqrt2 items (m=0, n=0
//   center) and an inverse row's values leave from ST_MUL, ST_EMIT or ST_EMIT_MUL instead.
// Throughput: one store or pair per cycle while the queues have room; a sqrt2 item holds the
//   back end until pushed; an inverse row of N+1 inputs then emits 2N+1 results.
// Reset (synchronous, rst_n low): config defaults, position m=0, queues empty, buffers kept.
module fourier_coef_layout_convert_unit #(
  parameter int MAX_M = fclc_pkg::MAX_M_DEF,
  parameter int MAX_N = fclc_pkg::MAX_N_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [fclc_pkg::VAL_W-1:0]    in_value_a,
  input  logic signed [fclc_pkg::VAL_W-1:0]    in_value_b,
  // result channel
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [fclc_pkg::VAL_W-1:0]    out_a,
  output logic signed [fclc_pkg::VAL_W-1:0]    out_b,
  output logic [fclc_pkg::M_W-1:0]             out_index_m,
  output logic signed [fclc_pkg::N_W-1:0]      out_index_n,
  output logic                                 out_row_end,
  output logic                                 out_set_end,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [fclc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fclc_pkg::CFG_W-1:0]           cfg_data
);
  import fclc_pkg::*;

  localparam int MW = idx_bits(MAX_M);
  localparam int NW = idx_bits(MAX_N);

  logic [CFG_W-1:0] mode_count_r, mode_count_nxt;
  logic [CFG_W-1:0] tor_count_r, tor_count_nxt;
  logic             three_d_r, three_d_nxt;
  logic             sine_r, sine_nxt;
  logic             inverse_r, inverse_nxt;
  logic             cfg_clear;

  logic [MW-1:0]    eff_m;
  logic [NW-1:0]    eff_n;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_head;
  logic [CMD_W-1:0] cmd_in_vec, cmd_head_vec;

  logic             res_push, res_full;
  res_t             res_in, res_head;
  logic [RES_W-1:0] res_in_vec, res_head_vec;

  // Configuration register writes
  always_comb begin
    mode_count_nxt = mode_count_r;
    tor_count_nxt  = tor_count_r;
    three_d_nxt    = three_d_r;
    sine_nxt       = sine_r;
    inverse_nxt    = inverse_r;
    cfg_clear      = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE_COUNT: begin
          mode_count_nxt = cfg_data;
          cfg_clear      = 1'b1;
        end
        CFG_TOR_COUNT: begin
          tor_count_nxt = cfg_data;
          cfg_clear     = 1'b1;
        end
        CFG_THREE_D: begin
          three_d_nxt = cfg_data[0];
          cfg_clear   = 1'b1;
        end
        CFG_SINE_PARITY: begin
          sine_nxt  = cfg_data[0];
          cfg_clear = 1'b1;
        end
        CFG_INVERSE: begin
          inverse_nxt = cfg_data[0];
          cfg_clear   = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_count_r <= CFG_W'(1);
      tor_count_r  <= '0;
      three_d_r    <= 1'b0;
      sine_r       <= 1'b0;
      inverse_r    <= 1'b0;
    end else begin
      mode_count_r <= mode_count_nxt;
      tor_count_r  <= tor_count_nxt;
      three_d_r    <= three_d_nxt;
      sine_r       <= sine_nxt;
      inverse_r    <= inverse_nxt;
    end
  end

  // Clamp counts to the supported range; a zero mode count acts as one
  always_comb begin
    if (mode_count_r == '0) begin
      eff_m = MW'(1);
    end else if (32'(mode_count_r) > MAX_M) begin
      eff_m = MW'(MAX_M);
    end else begin
      eff_m = MW'(mode_count_r);
    end
    if (32'(tor_count_r) > MAX_N) begin
      eff_n = NW'(MAX_N);
    end else begin
      eff_n = NW'(tor_count_r);
    end
  end

  fclc_front #(
    .MAX_M(MAX_M),
    .MAX_N(MAX_N)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (in_push),
    .value_a_i  (in_value_a),
    .value_b_i  (in_value_b),
    .clear_i    (cfg_clear),
    .eff_m_i    (eff_m),
    .eff_n_i    (eff_n),
    .inverse_i  (inverse_r),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  assign in_full    = cmd_full;
  assign cmd_in_vec = cmd_in;
  assign cmd_head   = cmd_t'(cmd_head_vec);

  // Command queue between front and back
  fclc_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_push),
    .data_i  (cmd_in_vec),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head_vec),
    .empty_o (cmd_empty)
  );

  fclc_back #(
    .MAX_N(MAX_N)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .eff_n_i     (eff_n),
    .three_d_i   (three_d_r),
    .sine_i      (sine_r),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  assign res_in_vec = res_in;
  assign res_head   = res_t'(res_head_vec);

  // Result queue toward the consumer
  fclc_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .data_i  (res_in_vec),
    .full_o  (res_full),
    .pop_i   (out_pop),
    .data_o  (res_head_vec),
    .empty_o (out_empty)
  );

  assign out_a       = res_head.a;
  assign out_b       = res_head.b;
  assign out_index_m = res_head.m;
  assign out_index_n = res_head.n;
  assign out_row_end = res_head.row_end;
  assign out_set_end = res_head.set_end;

endmodule

// File: design/fclc_checker.sv
// Port-level checks for the layout converter, bound to the top level.
module fclc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_a,
  input logic [31:0] out_b,
  input logic [3:0]  out_index_m,
  input logic [5:0]  out_index_n,
  input logic        out_row_end,
  input logic        out_set_end
);

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // The end of a set is always the end of a row
  a_set_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_set_end |-> out_row_end)
    else $error("set_end without row_end");

  // Mode zero only carries non-negative toroidal indexes
  a_m0_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_index_m == 4'd0 |-> !out_index_n[5])
    else $error("negative n in mode zero");

  // A result that is not taken stays in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_a) && $stable(out_b)
      && $stable(out_index_n) && $stable(out_row_end))
    else $error("waiting result changed");

  // The input only fills up after a request was offered
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input full without a request");

endmodule

bind fourier_coef_layout_convert_unit fclc_checker u_fclc_checker (.*);
